// File: src/wud_pkg.sv
// ----------------------------------------------------------------------------
// wud_pkg
// Shared types and constants for the wide unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package wud_pkg;

  localparam int NUM_WORDS  = 8;
  localparam int WORD_BITS  = 32;
  localparam int IDX_BITS   = 3;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int CNT_BITS   = $clog2(TOTAL_BITS);
  localparam int TDATA_BITS = ((IDX_BITS + 2 * WORD_BITS + 7) / 8) * 8;
  localparam int PAD_BITS   = TDATA_BITS - IDX_BITS - 2 * WORD_BITS;

  typedef logic [TOTAL_BITS-1:0] wide_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  we;
    idx_t  idx;
    word_t dividend;
    word_t divisor;
  } store_wr_t;

  typedef struct packed {
    logic  q_bit;
    wide_t rem;
  } step_res_t;

endpackage

`default_nettype wire

// File: src/wud_store.sv
// ----------------------------------------------------------------------------
// wud_store
// Operand word stores for dividend and divisor, with zero-divisor detect.
// ----------------------------------------------------------------------------
`default_nettype none

module wud_store (
  input  wire logic              clk,
  input  wire wud_pkg::store_wr_t wr,
  output wud_pkg::wide_t         dividend,
  output wud_pkg::wide_t         divisor,
  output logic                   divisor_zero
);
  import wud_pkg::*;

  word_t dividend_words [NUM_WORDS];
  word_t divisor_words  [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      dividend_words[wr.idx] <= wr.dividend;
      divisor_words[wr.idx]  <= wr.divisor;
    end
  end

  for (genvar g = 0; g < NUM_WORDS; g++) begin : g_flat
    assign dividend[g*WORD_BITS +: WORD_BITS] = dividend_words[g];
    assign divisor[g*WORD_BITS +: WORD_BITS]  = divisor_words[g];
  end

  assign divisor_zero = (divisor == '0);

endmodule

`default_nettype wire

// File: src/wud_step.sv
// ----------------------------------------------------------------------------
// wud_step
// One restoring shift-and-subtract step over the full operand width.
// ----------------------------------------------------------------------------
`default_nettype none

module wud_step (
  input  wire wud_pkg::wide_t     rem,
  input  wire logic               in_bit,
  input  wire wud_pkg::wide_t     divisor,
  output wud_pkg::step_res_t      res
);
  import wud_pkg::*;

  logic [TOTAL_BITS:0]   shifted;
  logic [TOTAL_BITS+1:0] diff;

  assign shifted = {rem, in_bit};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_comb begin
    res.q_bit = ~diff[TOTAL_BITS+1];
    if (res.q_bit) begin
      res.rem = diff[TOTAL_BITS-1:0];
    end else begin
      res.rem = shifted[TOTAL_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/wide_unsigned_divider_top.sv
// ----------------------------------------------------------------------------
// wide_unsigned_divider_top
// Multiword unsigned long division, loaded one word pair per transaction.
// ----------------------------------------------------------------------------
// channel  | signals                          | role
// s_axis   | tvalid tready tdata tlast        | operand word load, tlast starts
// m_axis   | tvalid tready tdata tuser tlast  | quotient/remainder word results
//
// a load transaction without tlast only stores its word pair
// a tlast load passes a setup state, then the shared shift-subtract step runs
// once per dividend bit unless the divisor is zero, then NUM_WORDS (8) result transactions
// s_axis_tready is low from the tlast load until the last result is taken
// m_axis stalls hold the current result word, rst clears the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module wide_unsigned_divider_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // word_index, dividend_word, divisor_word, zero pad
  input  wire logic [wud_pkg::TDATA_BITS-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // out_index, quotient_word, remainder_word, zero pad
  output logic [wud_pkg::TDATA_BITS-1:0]           m_axis_tdata,
  // zero_divisor
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast
);
  import wud_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [CNT_BITS-1:0] cnt;
  idx_t            emit_idx;
  wide_t           quo;
  wide_t           rem;
  logic            zdiv;

  store_wr_t       wr;
  wide_t           st_dividend;
  wide_t           st_divisor;
  logic            st_zero;
  step_res_t       step;

  logic            in_xfer;
  logic            out_xfer;
  logic            div_done;
  logic            emit_done;
  word_t           quo_word;
  word_t           rem_word;

  assign in_xfer   = s_axis_tvalid & s_axis_tready;
  assign out_xfer  = m_axis_tvalid & m_axis_tready;
  assign div_done  = (cnt == CNT_BITS'(TOTAL_BITS - 1));
  assign emit_done = (emit_idx == IDX_BITS'(NUM_WORDS - 1));

  always_comb begin
    wr.idx      = s_axis_tdata[IDX_BITS-1:0];
    wr.dividend = s_axis_tdata[IDX_BITS +: WORD_BITS];
    wr.divisor  = s_axis_tdata[IDX_BITS+WORD_BITS +: WORD_BITS];
    wr.we       = in_xfer && ({1'b0, wr.idx} < (IDX_BITS+1)'(NUM_WORDS));
  end

  wud_store u_store (
    .clk          (clk),
    .wr           (wr),
    .dividend     (st_dividend),
    .divisor      (st_divisor),
    .divisor_zero (st_zero)
  );

  wud_step u_step (
    .rem     (rem),
    .in_bit  (quo[TOTAL_BITS-1]),
    .divisor (st_divisor),
    .res     (step)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && s_axis_tlast) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (st_zero) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer && emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_START: begin
          cnt      <= '0;
          emit_idx <= '0;
        end
        ST_DIVIDE: begin
          cnt <= cnt + 1'b1;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            emit_idx <= emit_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      zdiv <= st_zero;
      rem  <= '0;
      if (st_zero) begin
        quo <= '0;
      end else begin
        quo <= st_dividend;
      end
    end else if (state == ST_DIVIDE) begin
      quo <= {quo[TOTAL_BITS-2:0], step.q_bit};
      rem <= step.rem;
    end
  end

  assign quo_word = quo[emit_idx*WORD_BITS +: WORD_BITS];
  assign rem_word = rem[emit_idx*WORD_BITS +: WORD_BITS];

  assign m_axis_tdata = {{PAD_BITS{1'b0}}, rem_word, quo_word, emit_idx};
  assign m_axis_tuser = zdiv;
  assign m_axis_tlast = emit_done;

`ifndef ASSERT_OFF
  a_last_load_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted during division");

  a_final_result_frees: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_axis_tlast) |=> s_axis_tready)
    else $error("block not ready after final result");

  a_zero_divisor_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (quo_word == '0 && rem_word == '0))
    else $error("nonzero result with zero divisor");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && $past(state) == ST_DIVIDE) |-> (cnt == $past(cnt) + 1'b1))
    else $error("step counter skipped");
`endif

endmodule

`default_nettype wire

// File: dv/wide_unsigned_divider_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_unsigned_divider_top_tb
// Streams operand word loads into the divider and checks every quotient and
// remainder word against a 256-bit division done here in plain arithmetic.
// A few directed frames cover all-ones operands, a dividend below the
// divisor and a zero divisor. Random frames of random length follow, under
// three idle patterns, one long output stall and drain pauses.
// ----------------------------------------------------------------------------

module wide_unsigned_divider_top_tb;

  import wud_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_LOADS = 160;
  localparam int LONG_HOLD    = 800;

  typedef struct {
    idx_t  idx;
    word_t dividend;
    word_t divisor;
    bit    last;
    bit    drain_first;
  } load_t;

  typedef struct {
    idx_t  idx;
    word_t quotient;
    word_t remainder;
    bit    zero_div;
    bit    last;
  } result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // word_index, dividend_word, divisor_word, zero pad
  logic [TDATA_BITS-1:0] s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // out_index, quotient_word, remainder_word, zero pad
  logic [TDATA_BITS-1:0] m_axis_tdata;
  // zero_divisor
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  load_t   pending_loads[$];
  load_t   cur_load;
  result_t expected_words[$];
  result_t want_word;
  word_t   dividend_words[NUM_WORDS];
  word_t   divisor_words[NUM_WORDS];

  int total_loads;
  int loads_done;
  int results_seen;
  int hold_left;
  bit hold_done;
  int err_cnt;
  int cycle_cnt;

  wide_unsigned_divider_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int idle_phase();
    if (loads_done * 3 < total_loads) begin
      return 0;
    end else if (loads_done * 3 < total_loads * 2) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_phase())
      0: begin
        return 29;
      end
      1: begin
        return 85;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_phase())
      0: begin
        return 85;
      end
      1: begin
        return 29;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic word_t pick_word(int zero_pct, int ones_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) begin
      return '0;
    end else if (roll < zero_pct + ones_pct) begin
      return '1;
    end else if (roll < zero_pct + ones_pct + 10) begin
      return word_t'($urandom_range(1, 15));
    end
    return word_t'($urandom);
  endfunction

  function automatic void push_load(int idx, word_t dvd, word_t dvs, bit last, bit drain);
    load_t ld;
    ld.idx         = idx_t'(idx);
    ld.dividend    = dvd;
    ld.divisor     = dvs;
    ld.last        = last;
    ld.drain_first = drain;
    pending_loads.push_back(ld);
  endfunction

  // full-width division of the stored operands, one result per word
  function automatic void predict_division();
    wide_t   num;
    wide_t   den;
    wide_t   quo;
    wide_t   rem;
    bit      zero_div;
    result_t res;
    for (int k = 0; k < NUM_WORDS; k++) begin
      num[k*WORD_BITS +: WORD_BITS] = dividend_words[k];
      den[k*WORD_BITS +: WORD_BITS] = divisor_words[k];
    end
    zero_div = (den == '0);
    if (zero_div) begin
      quo = '0;
      rem = '0;
    end else begin
      quo = num / den;
      rem = num % den;
    end
    for (int k = 0; k < NUM_WORDS; k++) begin
      res.idx       = idx_t'(k);
      res.quotient  = quo[k*WORD_BITS +: WORD_BITS];
      res.remainder = rem[k*WORD_BITS +: WORD_BITS];
      res.zero_div  = zero_div;
      res.last      = (k == NUM_WORDS - 1);
      expected_words.push_back(res);
    end
  endfunction

  function automatic void check_field(string name, logic [WORD_BITS-1:0] want,
                                      logic [WORD_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // stimulus
  initial begin
    int    n;
    int    rand_loads;
    bit    drain;
    word_t dvs;
    rst = 1'b1;

    // all-ones dividend over a divisor of one
    for (int k = 0; k < NUM_WORDS; k++) begin
      push_load(k, '1, (k == 0) ? word_t'(1) : '0, k == NUM_WORDS - 1, 1'b0);
    end
    // dividend below divisor, sent only after the previous results drained
    push_load(NUM_WORDS - 1, '0, word_t'(1), 1'b1, 1'b1);
    // zero divisor, loaded from the top word down
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      push_load(k, '1, '0, k == 0, 1'b0);
    end
    // all-ones word divisor
    push_load(0, '1, '1, 1'b1, 1'b0);
    push_load(3, '0, word_t'(32'h8000_0001), 1'b1, 1'b0);

    rand_loads = 0;
    while (rand_loads < RANDOM_LOADS) begin
      drain = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 19) == 0) begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          push_load(k, pick_word(10, 10), '0, k == NUM_WORDS - 1, drain && k == 0);
        end
        rand_loads += NUM_WORDS;
      end else begin
        n = $urandom_range(1, 9);
        for (int j = 0; j < n; j++) begin
          dvs = pick_word(40, 10);
          push_load($urandom_range(0, NUM_WORDS - 1), pick_word(10, 10), dvs,
                    j == n - 1, drain && j == 0);
        end
        rand_loads += n;
      end
    end
    total_loads = pending_loads.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (loads_done < total_loads || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("wide_unsigned_divider_top verification clean");
    end else begin
      $display("wide_unsigned_divider_top verification failed");
    end
    $finish;
  end

  // load driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      loads_done    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        loads_done <= loads_done + 1;
        dividend_words[cur_load.idx] = cur_load.dividend;
        divisor_words[cur_load.idx]  = cur_load.divisor;
        if (cur_load.last) begin
          predict_division();
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_loads.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct() &&
            (!pending_loads[0].drain_first || expected_words.size() == 0)) begin
          cur_load = pending_loads.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{PAD_BITS{1'b0}}, cur_load.divisor, cur_load.dividend,
                            cur_load.idx};
          s_axis_tlast  <= cur_load.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      results_seen  = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result transaction: tdata 0x%0h", m_axis_tdata);
          err_cnt++;
        end else begin
          want_word = expected_words.pop_front();
          check_field("out_index", want_word.idx, m_axis_tdata[IDX_BITS-1:0]);
          check_field("quotient_word", want_word.quotient,
                      m_axis_tdata[IDX_BITS +: WORD_BITS]);
          check_field("remainder_word", want_word.remainder,
                      m_axis_tdata[IDX_BITS + WORD_BITS +: WORD_BITS]);
          check_field("zero_divisor", want_word.zero_div, m_axis_tuser);
          check_field("out_last", want_word.last, m_axis_tlast);
        end
        results_seen++;
        if (results_seen == 2 * NUM_WORDS && !hold_done) begin
          hold_left = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("wide_unsigned_divider_top verification failed");
      $finish;
    end
  end

endmodule
